// File: hw/rtl/sspm_pkg.sv
// Package for the stream suffix pattern matcher: command codes and the
// front-to-back queue entry type. No dependencies.
`default_nettype none
package sspm_pkg;
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_STREAM = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       pattern_end;
    } item_t;
endpackage
`default_nettype wire

// File: hw/rtl/sspm_front.sv
// Front end: accepts input items into a two-entry queue.
// Depends on sspm_pkg.
`default_nettype none
module sspm_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire sspm_pkg::item_t in_item,
    output logic                q_valid,
    input  wire logic           q_ready,
    output sspm_pkg::item_t     q_item
);
    import sspm_pkg::*;

    item_t      buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/sspm_back.sv
// Back end: pattern table, history window and parallel suffix compare.
// Depends on sspm_pkg.
`default_nettype none
module sspm_back #(
    parameter int NUM_PATTERNS = 16,
    parameter int MAX_LEN      = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire sspm_pkg::item_t q_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 match,
    output logic                 load_error
);
    import sspm_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(NUM_PATTERNS + 1);
    localparam int PW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

    // Each row holds its pattern reversed: index 0 is the last byte loaded,
    // so cell 0 lines up with the incoming byte and cell i with window byte i-1.
    logic [7:0]    pat_reg  [NUM_PATTERNS][MAX_LEN];
    logic [LW-1:0] plen_reg [NUM_PATTERNS];
    logic [7:0]    hist_reg [MAX_LEN];
    logic [CW-1:0] count_reg;
    logic [LW-1:0] pos_reg, longest_reg, fill_reg, fill_next;
    logic          ov_reg, match_reg, err_reg;
    logic          take, full, do_store, commit;
    logic [LW-1:0] pos_after;
    logic [NUM_PATTERNS-1:0] hit;

    assign q_ready    = !ov_reg || out_ready;
    assign take       = q_valid && q_ready;
    assign out_valid  = ov_reg;
    assign match      = match_reg;
    assign load_error = err_reg;

    assign full      = (count_reg == CW'(NUM_PATTERNS));
    assign do_store  = !full && (pos_reg < LW'(MAX_LEN));
    assign pos_after = pos_reg + LW'(do_store);
    assign commit    = !full && q_item.pattern_end && (pos_after != '0);
    assign fill_next = (fill_reg < longest_reg) ? fill_reg + LW'(1) : longest_reg;

    // Compare every committed pattern against the newest window bytes.
    always_comb
    begin
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            hit[p] = (CW'(p) < count_reg) && (plen_reg[p] != '0)
                     && (plen_reg[p] <= fill_next);
            for (int i = 0; i < MAX_LEN; i++)
            begin
                if (LW'(i) < plen_reg[p])
                begin
                    if (i == 0)
                    begin
                        if (pat_reg[p][0] != q_item.data_byte)
                            hit[p] = 1'b0;
                    end
                    else if (pat_reg[p][i] != hist_reg[i-1])
                    begin
                        hit[p] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            if (take && q_item.command == CMD_LOAD && do_store && CW'(p) == count_reg)
            begin
                pat_reg[p][0] <= q_item.data_byte;
                for (int i = 1; i < MAX_LEN; i++)
                begin
                    pat_reg[p][i] <= pat_reg[p][i-1];
                end
            end
        end
        if (take && q_item.command == CMD_STREAM)
        begin
            hist_reg[0] <= q_item.data_byte;
            for (int i = 1; i < MAX_LEN; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pos_reg     <= '0;
            longest_reg <= '0;
            fill_reg    <= '0;
            ov_reg      <= 1'b0;
            match_reg   <= 1'b0;
            err_reg     <= 1'b0;
            for (int p = 0; p < NUM_PATTERNS; p++)
            begin
                plen_reg[p] <= '0;
            end
        end
        else
        begin
            ov_reg <= take || (ov_reg && !out_ready);
            if (take)
            begin
                case (q_item.command)
                    CMD_CLEAR:
                    begin
                        match_reg   <= 1'b0;
                        err_reg     <= 1'b0;
                        count_reg   <= '0;
                        pos_reg     <= '0;
                        longest_reg <= '0;
                        fill_reg    <= '0;
                        for (int p = 0; p < NUM_PATTERNS; p++)
                        begin
                            plen_reg[p] <= '0;
                        end
                    end
                    CMD_LOAD:
                    begin
                        match_reg <= 1'b0;
                        err_reg   <= !do_store;
                        if (full || q_item.pattern_end)
                            pos_reg <= '0;
                        else
                            pos_reg <= pos_after;
                        if (commit)
                        begin
                            plen_reg[PW'(count_reg)] <= pos_after;
                            count_reg <= count_reg + CW'(1);
                            if (pos_after > longest_reg)
                                longest_reg <= pos_after;
                        end
                    end
                    CMD_STREAM:
                    begin
                        err_reg   <= 1'b0;
                        fill_reg  <= fill_next;
                        match_reg <= |hit;
                    end
                    default:
                    begin
                        match_reg <= 1'b0;
                        err_reg   <= 1'b0;
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/stream_suffix_multi_pattern_match.sv
// Stream suffix multi-pattern matcher, top level.
// Path: an item is registered in the queue, then compared; result registered.
// Throughput: one item per cycle if out_ready; all patterns compared at once.
// Reset: rst_n asynchronous, clears table lengths, counts, fill and queue.
// Depends on sspm_pkg, sspm_front, sspm_back.
`default_nettype none
module stream_suffix_multi_pattern_match #(
    parameter int NUM_PATTERNS = 16,
    parameter int MAX_LEN      = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] command,
    input  wire logic [7:0] data_byte,
    input  wire logic       pattern_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            match,
    output logic            load_error
);
    import sspm_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_ready;

    // Bundle the input fields into one queue entry.
    assign in_item = '{command: command, data_byte: data_byte, pattern_end: pattern_end};

    // Front: hold items in a short queue so input and output stall apart.
    sspm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    // Back: execute clear, load and stream commands; register the result.
    sspm_back #(.NUM_PATTERNS(NUM_PATTERNS), .MAX_LEN(MAX_LEN)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready),
        .match(match), .load_error(load_error)
    );
endmodule
`default_nettype wire

// File: tb/stream_suffix_multi_pattern_match_test.sv
// Testbench for the stream suffix multi-pattern matcher: loads pattern tables,
// streams bytes and checks match / load_error against a built-in predictor.
// Depends on sspm_pkg and stream_suffix_multi_pattern_match.
`timescale 1ns / 1ps
module stream_suffix_multi_pattern_match_test;
    import sspm_pkg::*;

    localparam int NPAT = 16;
    localparam int MLEN = 16;
    localparam int IDLE_PCT = 17;
    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic m;
        logic err;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] command = CMD_CLEAR;
    logic [7:0] data_byte = 8'd0;
    logic       pattern_end = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       match;
    logic       load_error;

    // Predictor state: the pattern table and the stream history window.
    logic [7:0] pat_bytes [NPAT][MLEN];
    int         pat_len [NPAT];
    int         pat_count;
    int         load_pos;
    int         longest;
    logic [7:0] window [MLEN];
    int         fill;

    verdict_t   pending_verdicts[$];
    int         failures = 0;
    int         quiet_cycles = 0;
    bit         calm = 1'b0;      // no idling on either side
    bit         hold_off = 1'b0;  // receiver holds back for a long stretch

    stream_suffix_multi_pattern_match u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .data_byte(data_byte), .pattern_end(pattern_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .match(match), .load_error(load_error)
    );

    always #6 clk = ~clk;

    // Advance the predictor by one item and return its verdict.
    function automatic verdict_t predict_item(logic [1:0] cmd, logic [7:0] b, logic last);
        verdict_t v;
        bit hit;
        v.m = 1'b0;
        v.err = 1'b0;
        if (cmd == CMD_CLEAR)
        begin
            for (int p = 0; p < NPAT; p++) pat_len[p] = 0;
            pat_count = 0;
            load_pos = 0;
            longest = 0;
            fill = 0;
        end
        else if (cmd == CMD_LOAD)
        begin
            if (pat_count >= NPAT)
            begin
                v.err = 1'b1;
                load_pos = 0;
            end
            else
            begin
                if (load_pos < MLEN)
                begin
                    pat_bytes[pat_count][load_pos] = b;
                    load_pos++;
                end
                else
                begin
                    v.err = 1'b1;
                end
                if (last)
                begin
                    if (load_pos > 0)
                    begin
                        pat_len[pat_count] = load_pos;
                        if (load_pos > longest) longest = load_pos;
                        pat_count++;
                    end
                    load_pos = 0;
                end
            end
        end
        else if (cmd == CMD_STREAM)
        begin
            for (int i = MLEN - 1; i > 0; i--) window[i] = window[i - 1];
            window[0] = b;
            if (fill < longest) fill++;
            for (int p = 0; p < pat_count; p++)
            begin
                if (pat_len[p] > 0 && pat_len[p] <= fill)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < pat_len[p]; i++)
                        if (pat_bytes[p][pat_len[p] - 1 - i] != window[i]) hit = 1'b0;
                    if (hit) v.m = 1'b1;
                end
            end
        end
        return v;
    endfunction

    // Offer one item; hold valid and payload until the transfer happens.
    // Valid stays high after the transfer so items can follow back to back.
    task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic last);
        verdict_t v;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= b;
        pattern_end <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        v = predict_item(cmd, b, last);
        pending_verdicts.insert(pending_verdicts.size(), v);
        @(negedge clk);
    endtask

    task automatic load_pattern(logic [7:0] bytes[$]);
        foreach (bytes[i]) send_item(CMD_LOAD, bytes[i], i == bytes.size() - 1);
    endtask

    // Receiver readiness: random idling unless calm, never ready during a hold-off.
    always @(negedge clk)
    begin
        if (hold_off) out_ready <= 1'b0;
        else if (calm) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result match=%b load_error=%b",
                         $time, match, load_error);
                failures++;
            end
            else
            begin
                exp_v = pending_verdicts[0];
                pending_verdicts.delete(0);
                if (match !== exp_v.m)
                begin
                    $display("%0t: match expected %b actual %b", $time, exp_v.m, match);
                    failures++;
                end
                if (load_error !== exp_v.err)
                begin
                    $display("%0t: load_error expected %b actual %b",
                             $time, exp_v.err, load_error);
                    failures++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("stream_suffix_multi_pattern_match: mismatch");
            $finish;
        end
    end

    task automatic test_extremes;
        send_item(CMD_STREAM, 8'h00, 1'b1);  // no patterns: never a match
        load_pattern('{8'hFF});
        load_pattern('{8'h00, 8'hA5});
        send_item(CMD_STREAM, 8'hFF, 1'b0);
        send_item(CMD_STREAM, 8'h00, 1'b0);
        send_item(CMD_STREAM, 8'hA5, 1'b0);
        send_item(CMD_UNUSED, 8'h5A, 1'b1);  // unused command
        send_item(CMD_LOAD, 8'h11, 1'b1);    // one-byte pattern, no wider than the longest
        send_item(CMD_STREAM, 8'h11, 1'b0);
        send_item(CMD_CLEAR, 8'hFF, 1'b1);
        send_item(CMD_STREAM, 8'hFF, 1'b0);
    endtask

    task automatic test_overflow;
        // Too long: 18 bytes, the last two dropped, then committed truncated.
        for (int i = 0; i < MLEN + 2; i++) send_item(CMD_LOAD, 8'(i), i == MLEN + 1);
        for (int i = 0; i < MLEN; i++) send_item(CMD_STREAM, 8'(i), 1'b0);
        // Fill the table, then bytes dropped when full.
        for (int p = 0; p < NPAT; p++) send_item(CMD_LOAD, 8'(p + 8'h80), 1'b1);
        send_item(CMD_LOAD, 8'h42, 1'b0);
        send_item(CMD_LOAD, 8'h43, 1'b1);
        send_item(CMD_STREAM, 8'h8F, 1'b0);
        send_item(CMD_CLEAR, 8'h00, 1'b0);
    endtask

    // Mostly well-formed: load a few short patterns, then stream from a
    // small alphabet so that hits are frequent; occasional noise and clears.
    task automatic test_random;
        int n_pat, len, n_stream;
        int sent = 0;
        while (sent < 780)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
                sent++;
                continue;
            end
            send_item(CMD_CLEAR, 8'($urandom), 1'($urandom));
            sent++;
            n_pat = $urandom_range(1, 18);
            for (int p = 0; p < n_pat; p++)
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_item(CMD_LOAD,
                              ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
                              i == len - 1);
                sent += len;
            end
            n_stream = $urandom_range(20, 60);
            for (int i = 0; i < n_stream; i++)
            begin
                send_item(CMD_STREAM,
                          ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
                          1'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_backpressure;
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 30; i++) send_item(CMD_STREAM, 8'($urandom_range(3)), 1'b0);
        join
    endtask

    task automatic test_calm_stretch;
        calm = 1'b1;
        for (int i = 0; i < 150; i++)
            send_item(($urandom_range(4) == 0) ? CMD_LOAD : CMD_STREAM,
                      8'($urandom_range(3)), 1'($urandom));
        calm = 1'b0;
    endtask

    initial
    begin
        for (int p = 0; p < NPAT; p++) pat_len[p] = 0;
        pat_count = 0;
        load_pos = 0;
        longest = 0;
        fill = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_extremes();
        test_overflow();
        test_backpressure();
        test_calm_stretch();
        test_random();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (failures == 0) $display("stream_suffix_multi_pattern_match: match");
        else $display("stream_suffix_multi_pattern_match: mismatch");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/sspm_pkg.sv
hw/rtl/sspm_front.sv
hw/rtl/sspm_back.sv
hw/rtl/stream_suffix_multi_pattern_match.sv
tb/stream_suffix_multi_pattern_match_test.sv
